// ===== rtl/srp_pkg.sv =====
// Package with the shared types, constants and codes of the shelf atlas rectangle packer.
package srp_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int MAX_PAGES = 64;

  localparam int DIM_W   = 13;
  localparam int PAGES_W = 7;
  localparam int RECT_W  = 16;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_PAGE_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_PAGE_WIDTH  = 2'd0,
    REG_PAGE_HEIGHT = 2'd1,
    REG_PAGE_LIMIT  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [PAGES_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]   pos_x;
    logic [DIM_W-1:0]   pos_y;
    logic [DIM_W-1:0]   shelf_rows;
    logic [PAGES_W-1:0] pages_open;
    logic [DIM_W-1:0]   fill_rows;
  } pack_state_t;

  typedef struct packed {
    logic              new_set;
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
  } rect_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  page_index;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [12:0] page_fill;
  } result_t;

endpackage

// ===== rtl/srp_cfg.sv =====
// APB register file holding the page geometry and page limit, with clamped effective values.
module srp_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [srp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [srp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [srp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output srp_pkg::cfg_t             cfg_eff
);
  import srp_pkg::*;

  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [PAGES_W-1:0] limit_r;
  logic               wr_en;
  reg_idx_t           idx;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1024);
      height_r <= DIM_W'(1024);
      limit_r  <= PAGES_W'(16);
    end else if (wr_en) begin
      unique case (idx)
        REG_PAGE_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_PAGE_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        REG_PAGE_LIMIT:  limit_r  <= cfg_pwdata[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAGE_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_PAGE_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      REG_PAGE_LIMIT:  cfg_prdata = CFG_DW'(limit_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg_eff.width  = (width_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_r;
    cfg_eff.height = (height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_r;
    if (limit_r == '0) begin
      cfg_eff.limit = PAGES_W'(1);
    end else if (limit_r > PAGES_W'(MAX_PAGES)) begin
      cfg_eff.limit = PAGES_W'(MAX_PAGES);
    end else begin
      cfg_eff.limit = limit_r;
    end
  end

endmodule

// ===== rtl/srp_place.sv =====
// Placement logic: one next-fit shelf step from the packing state and one rectangle.
module srp_place (
  input  srp_pkg::cfg_t        cfg,
  input  srp_pkg::pack_state_t cur,
  input  srp_pkg::rect_t       rect,
  output srp_pkg::pack_state_t nxt,
  output srp_pkg::result_t     res
);
  import srp_pkg::*;

  pack_state_t       base;
  logic [16:0]       pw;
  logic [16:0]       ph;
  logic [DIM_W-1:0]  pw13;
  logic [DIM_W-1:0]  ph13;
  logic              too_big;
  logic [PAGES_W-1:0] np0;
  logic [DIM_W-1:0]  uh0;
  logic              wrap;
  logic [DIM_W:0]    cy_sum;
  logic [DIM_W-1:0]  cx1;
  logic [DIM_W-1:0]  cy1;
  logic [DIM_W-1:0]  sh1;
  logic              new_page;
  logic              limit_hit;
  logic [PAGES_W-1:0] np2;
  logic [DIM_W-1:0]  cx2;
  logic [DIM_W-1:0]  cy2;
  logic [DIM_W-1:0]  sh2;
  logic [DIM_W-1:0]  uh2;
  logic [DIM_W:0]    bottom;
  logic [PAGES_W-1:0] page_num;

  always_comb begin
    base = rect.new_set ? '0 : cur;

    pw   = {1'b0, rect.rect_width} + 17'd2;
    ph   = {1'b0, rect.rect_height} + 17'd2;
    pw13 = pw[DIM_W-1:0];
    ph13 = ph[DIM_W-1:0];

    too_big = (pw > {4'b0, cfg.width}) || (ph > {4'b0, cfg.height});

    np0 = (base.pages_open == '0) ? PAGES_W'(1) : base.pages_open;
    uh0 = (base.pages_open == '0) ? '0 : base.fill_rows;

    // A rectangle that runs past the row end starts a new shelf.
    wrap   = ({5'b0, base.pos_x} + {1'b0, pw}) > {5'b0, cfg.width};
    cy_sum = {1'b0, base.pos_y} + {1'b0, base.shelf_rows};
    if (wrap) begin
      cx1 = '0;
      cy1 = (cy_sum > {1'b0, cfg.height}) ? cfg.height : cy_sum[DIM_W-1:0];
      sh1 = '0;
    end else begin
      cx1 = base.pos_x;
      cy1 = base.pos_y;
      sh1 = base.shelf_rows;
    end

    new_page  = ({5'b0, cy1} + {1'b0, ph}) > {5'b0, cfg.height};
    limit_hit = new_page && (np0 >= cfg.limit);

    if (new_page) begin
      np2 = np0 + PAGES_W'(1);
      cx2 = '0;
      cy2 = '0;
      sh2 = '0;
      uh2 = '0;
    end else begin
      np2 = np0;
      cx2 = cx1;
      cy2 = cy1;
      sh2 = sh1;
      uh2 = uh0;
    end

    bottom   = {1'b0, cy2} + {1'b0, ph13};
    page_num = np2 - PAGES_W'(1);

    res = '0;
    nxt = base;
    if (too_big) begin
      res.status = ST_TOO_LARGE;
    end else if (limit_hit) begin
      res.status = ST_PAGE_FULL;
    end else begin
      nxt.pos_x      = cx2 + pw13;
      nxt.pos_y      = cy2;
      nxt.shelf_rows = (ph13 > sh2) ? ph13 : sh2;
      nxt.pages_open = np2;
      nxt.fill_rows  = (bottom[DIM_W-1:0] > uh2) ? bottom[DIM_W-1:0] : uh2;
      res.status     = ST_PLACED;
      res.page_index = page_num[5:0];
      res.origin_x   = cx2[11:0];
      res.origin_y   = cy2[11:0];
      res.page_fill  = nxt.fill_rows;
    end
  end

endmodule

// ===== rtl/shelf_atlas_rect_packer.sv =====
// Top level of the shelf atlas rectangle packer: input register, placement step, result register.
// A beat goes from the input register through the placement step into the result register.
// Throughput: one rectangle per cycle unless out_* stalls; the state loop holds one register.
// Both registers advance when the result is taken or empty; the input one also fills when empty.
// Reset (rst_n low, synchronous) clears both valid flags and the packing state, and loads
// the registers with page width 1024, page height 1024 and page limit 16.
module shelf_atlas_rect_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,   // rect_width[15:0], rect_height[31:16]
  input  logic [0:0]                 in_tuser,   // new_set[0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [47:0]                out_tdata,  // page_index[5:0], origin_x[17:6],
                                                 // origin_y[29:18], page_fill[42:30]
  output logic [1:0]                 out_tuser,  // status[1:0]
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [srp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [srp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [srp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import srp_pkg::*;

  cfg_t        cfg_eff;
  rect_t       rect_r;
  logic        in_valid_r;
  pack_state_t state_r;
  pack_state_t state_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic        out_valid_r;
  logic        out_free;
  logic        advance;

  srp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_eff     (cfg_eff)
  );

  srp_place u_place (
    .cfg  (cfg_eff),
    .cur  (state_r),
    .rect (rect_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rect_r.new_set     <= in_tuser[0];
      rect_r.rect_width  <= in_tdata[15:0];
      rect_r.rect_height <= in_tdata[31:16];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {5'b0, res_r.page_fill, res_r.origin_y,
                       res_r.origin_x, res_r.page_index};

endmodule
